/* rtl/prr_pkg.sv */
// prr_pkg: sizes, field layout, codes and shared types of the polyphase
// rational resampler. No dependencies; imported by prr_div, prr_mac
// and by the top level.
package prr_pkg;

    // filter geometry
    localparam int TAPS        = 32;
    localparam int PHASES      = 64;
    localparam int MAX_RESULTS = 64;
    localparam int COEF_DEPTH  = PHASES * TAPS;

    // fixed field widths
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_ADDR_W = 11;
    localparam int Q_FRAC      = 14;
    localparam int INTERP_W    = 7;
    localparam int DECIM_W     = 8;
    localparam int IA_W        = 8;

    // derived widths
    localparam int CA_W   = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int TAP_W  = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int PH_W   = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int LW     = $clog2(PHASES + 1);
    localparam int SUM_W  = $clog2(PHASES + 255);
    localparam int RUN_W  = $clog2(MAX_RESULTS + 1);
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    // stream layout
    localparam int S_TDATA_W     = 48;
    localparam int S_SAMPLE_LSB  = 0;
    localparam int S_ADDR_LSB    = S_SAMPLE_LSB + SAMPLE_W;
    localparam int S_COEF_LSB    = S_ADDR_LSB + COEF_ADDR_W;
    localparam int M_TDATA_W     = SAMPLE_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = CFG_IDX_W'(1);

    localparam logic [INTERP_W-1:0] INTERP_RST = INTERP_W'(40);
    localparam logic [DECIM_W-1:0]  DECIM_RST  = DECIM_W'(147);

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_COEF   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_WAIT
    } state_t;

    // one tap on its way into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

/* rtl/polyphase_rational_resampler.sv */
// polyphase_rational_resampler: top level. Sequencer, delay line and
// coefficient RAMs, output register. Depends on prr_pkg, prr_ram, prr_div,
// prr_mac.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tuser opcode; s_tdata sample_in,
//                                     coef_address, coef_value
//  m_       out  m_tvalid/m_tready    m_tdata sample_out; m_tlast last_in_run
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A coefficient transfer writes the coefficient RAM. A sample transfer
// pushes into the delay line and may start a run; each output of a run
// reads TAPS taps through the shared multiply-accumulate and the RAM/MAC
// pipeline into the output register. The phase divider runs alongside.
// The output register holds one finished result; a stalled m_ side holds the
// next output in the MAC and stops the sequencer until the register frees.
// Input and configuration are taken only between runs. Reset is synchronous
// and needs no clearing pass: a fill count masks delay entries not written.
module polyphase_rational_resampler import prr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sample_in, coef_address, coef_value, 5'b0
    input  logic                  s_tuser,   // opcode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // sample_out
    output logic                  m_tlast,   // last_in_run
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // registers
    state_t               state_reg, state_next;
    logic [INTERP_W-1:0]  interp_reg, interp_next;
    logic [DECIM_W-1:0]   decim_reg, decim_next;
    logic [TAP_W-1:0]     wp_reg, wp_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [TAP_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [TAP_W-1:0]     tap_cnt_reg, tap_cnt_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic [IA_W-1:0]      ahead_reg, ahead_next;
    logic [RUN_W-1:0]     run_cnt_reg, run_cnt_next;
    mac_ctl_t             ctl_d1_reg, ctl_d1_next;
    logic                 ok_d1_reg, ok_d1_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]  m_data_reg;
    logic                 m_last_reg;

    // input fields
    logic [SAMPLE_W-1:0]    sample_in;
    logic [COEF_ADDR_W-1:0] coef_addr_in;
    logic [COEF_W-1:0]      coef_value_in;
    logic                   s_xfer;
    logic                   cfg_xfer;

    // effective ratio
    logic [LW-1:0]      l_eff;
    logic [DECIM_W-1:0] m_eff;

    // RAM ports
    logic               dl_we;
    logic [SAMPLE_W-1:0] dl_rdata;
    logic               coef_we;
    logic [CA_W-1:0]    coef_waddr;
    logic [CA_W-1:0]    coef_raddr;
    logic [COEF_W-1:0]  coef_rdata;

    // datapath
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quot;
    logic [LW-1:0]      div_rem;
    logic               mac_rdy;
    logic signed [SAMPLE_W-1:0] mac_y;
    logic signed [SAMPLE_W-1:0] mac_sample;
    logic               out_load;
    logic               out_last;
    logic [TAP_W-1:0]   rd_start;

    assign sample_in     = s_tdata[S_SAMPLE_LSB +: SAMPLE_W];
    assign coef_addr_in  = s_tdata[S_ADDR_LSB +: COEF_ADDR_W];
    assign coef_value_in = s_tdata[S_COEF_LSB +: COEF_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // zero reads as one, rows beyond the coefficient store clamp to PHASES
    always_comb begin
        if (interp_reg == '0) begin
            l_eff = LW'(1);
        end else if (32'(interp_reg) > PHASES) begin
            l_eff = LW'(PHASES);
        end else begin
            l_eff = LW'(interp_reg);
        end
        m_eff = (decim_reg == '0) ? DECIM_W'(1) : decim_reg;
    end

    assign coef_waddr = CA_W'(coef_addr_in);
    assign coef_raddr = CA_W'(32'(phase_reg) * TAPS + 32'(tap_cnt_reg));
    assign rd_start   = (wp_reg == '0) ? TAP_W'(TAPS - 1) : wp_reg - 1'b1;

    // ends the run after this output when another input is needed or the run reaches MAX_RESULTS outputs
    assign out_last = (div_quot != '0) || (run_cnt_reg == RUN_W'(MAX_RESULTS - 1));

    always_comb begin
        state_next    = state_reg;
        interp_next   = interp_reg;
        decim_next    = decim_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        rd_ptr_next   = rd_ptr_reg;
        tap_cnt_next  = tap_cnt_reg;
        phase_next    = phase_reg;
        ahead_next    = ahead_reg;
        run_cnt_next  = run_cnt_reg;
        ctl_d1_next   = '0;
        ok_d1_next    = 1'b0;
        dl_we         = 1'b0;
        coef_we       = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;

        if (cfg_xfer) begin
            case (cfg_index)
                CFG_INTERP: interp_next = INTERP_W'(cfg_data);
                CFG_DECIM:  decim_next  = DECIM_W'(cfg_data);
                default:    ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    if (op_t'(s_tuser) == OP_COEF) begin
                        coef_we = 32'(coef_addr_in) < COEF_DEPTH;
                    end else begin
                        dl_we        = 1'b1;
                        wp_next      = (wp_reg == TAP_W'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
                        fill_next    = (fill_reg == FILL_W'(TAPS)) ? fill_reg
                                                                   : fill_reg + 1'b1;
                        // newest sample sits at the old write pointer
                        rd_ptr_next  = wp_reg;
                        tap_cnt_next = '0;
                        run_cnt_next = '0;
                        if (LW'(phase_reg) >= l_eff) begin
                            phase_next = '0;
                        end
                        ahead_next = (ahead_reg != '0) ? ahead_reg - 1'b1 : '0;
                        if (ahead_reg <= IA_W'(1)) begin
                            state_next = S_MAC;
                        end
                    end
                end
            end
            S_MAC: begin
                div_start         = (tap_cnt_reg == '0);
                ctl_d1_next.valid = 1'b1;
                ctl_d1_next.first = (tap_cnt_reg == '0);
                ctl_d1_next.last  = (tap_cnt_reg == TAP_W'(TAPS - 1));
                ok_d1_next        = FILL_W'(rd_ptr_reg) < fill_reg;
                // TAPS decrements bring the pointer back for the next output
                rd_ptr_next = (rd_ptr_reg == '0) ? TAP_W'(TAPS - 1) : rd_ptr_reg - 1'b1;
                if (tap_cnt_reg == TAP_W'(TAPS - 1)) begin
                    tap_cnt_next = '0;
                    state_next   = S_WAIT;
                end else begin
                    tap_cnt_next = tap_cnt_reg + 1'b1;
                end
            end
            S_WAIT: begin
                if (mac_rdy && div_done && (!m_tvalid_reg || m_tready)) begin
                    out_load     = 1'b1;
                    phase_next   = PH_W'(div_rem);
                    ahead_next   = IA_W'(div_quot);
                    run_cnt_next = run_cnt_reg + 1'b1;
                    state_next   = out_last ? S_IDLE : S_MAC;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            interp_reg   <= INTERP_RST;
            decim_reg    <= DECIM_RST;
            wp_reg       <= '0;
            fill_reg     <= '0;
            rd_ptr_reg   <= '0;
            tap_cnt_reg  <= '0;
            phase_reg    <= '0;
            ahead_reg    <= IA_W'(1);
            run_cnt_reg  <= '0;
            ctl_d1_reg   <= '0;
            ok_d1_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            interp_reg   <= interp_next;
            decim_reg    <= decim_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            rd_ptr_reg   <= rd_ptr_next;
            tap_cnt_reg  <= tap_cnt_next;
            phase_reg    <= phase_next;
            ahead_reg    <= ahead_next;
            run_cnt_reg  <= run_cnt_next;
            ctl_d1_reg   <= ctl_d1_next;
            ok_d1_reg    <= ok_d1_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (out_load) begin
            m_data_reg <= mac_y;
            m_last_reg <= out_last;
        end
    end

    // delay line: TAPS entries, written at push, read newest first
    prr_ram #(
        .DEPTH (TAPS),
        .WIDTH (SAMPLE_W)
    ) u_dl_ram (
        .aclk  (aclk),
        .we    (dl_we),
        .waddr (wp_reg),
        .wdata (sample_in),
        .raddr (rd_ptr_reg),
        .rdata (dl_rdata)
    );

    // coefficients, row * TAPS + tap
    prr_ram #(
        .DEPTH (COEF_DEPTH),
        .WIDTH (COEF_W)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_value_in),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    prr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (SUM_W'(phase_reg) + SUM_W'(m_eff)),
        .divisor  (l_eff),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // entries not yet written since reset read as zero
    assign mac_sample = ok_d1_reg ? dl_rdata : '0;

    prr_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl_d1_reg),
        .coef    (coef_rdata),
        .sample  (mac_sample),
        .rdy     (mac_rdy),
        .y       (mac_y)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // phase stays a valid row while a run is in progress
    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> LW'(phase_reg) < l_eff)
        else $error("phase out of range during run");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(TAPS))
        else $error("fill count beyond delay depth");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");

    // each output starts reading at the newest sample
    a_rd_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC && tap_cnt_reg == '0) |-> rd_ptr_reg == rd_start)
        else $error("delay read pointer misaligned");

endmodule

/* rtl/prr_ram.sv */
// prr_ram: generic single-clock RAM, one write port, one read port,
// registered read data. No dependencies.
module prr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/prr_div.sv */
// prr_div: serial restoring divider, one quotient bit per cycle, used for
// the phase step (phase + M) / L and its remainder. Depends on prr_pkg.
module prr_div import prr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [LW-1:0]    divisor,
    output logic             done,
    output logic [SUM_W-1:0] quot,
    output logic [LW-1:0]    rem
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] q_reg, q_next;
    logic [LW-1:0]    r_reg, r_next;
    logic [LW-1:0]    d_reg, d_next;
    logic [LW:0]      trial;
    logic [LW:0]      diff;
    logic             take;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[SUM_W-1]};
        diff      = trial - {1'b0, d_reg};
        take      = trial >= {1'b0, d_reg};
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            q_next = {q_reg[SUM_W-2:0], take};
            r_next = take ? LW'(diff) : LW'(trial);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

/* rtl/prr_mac.sv */
// prr_mac: multiply-accumulate pipeline (product, accumulate, round and
// saturate) for one output. Depends on prr_pkg.
module prr_mac import prr_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mac_ctl_t                   ctl,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       rdy,
    output logic signed [SAMPLE_W-1:0] y
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((2 ** Q_FRAC) - 1);

    mac_ctl_t                   ctl_a_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       acc_done_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    adj;
    logic signed [ACC_W-1:0]    q_full;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic                       rdy_reg, rdy_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctl_a_reg.valid) begin
            acc_next = ctl_a_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        // shift toward zero: bias negatives before the arithmetic shift
        adj    = acc_reg + (acc_reg[ACC_W-1] ? BIAS : '0);
        q_full = adj >>> Q_FRAC;
        if (q_full > SAT_MAX) begin
            y_next = SAMPLE_W'(SAT_MAX);
        end else if (q_full < SAT_MIN) begin
            y_next = SAMPLE_W'(SAT_MIN);
        end else begin
            y_next = SAMPLE_W'(q_full);
        end
        rdy_next = rdy_reg;
        if (ctl.valid && ctl.first) begin
            rdy_next = 1'b0;
        end else if (acc_done_reg) begin
            rdy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg    <= '0;
            acc_done_reg <= 1'b0;
            rdy_reg      <= 1'b0;
        end else begin
            ctl_a_reg    <= ctl;
            acc_done_reg <= ctl_a_reg.valid && ctl_a_reg.last;
            rdy_reg      <= rdy_next;
        end
        prod_reg <= coef * sample;
        acc_reg  <= acc_next;
        if (acc_done_reg) begin
            y_reg <= y_next;
        end
    end

    assign rdy = rdy_reg;
    assign y   = y_reg;

endmodule
